FILE: hdl/nearest_point_search_3d_defines.svh
// Assertion macros for the nearest point search block.
// Each use expects aclk and aresetn in the enclosing module.
`ifndef NEAREST_POINT_SEARCH_3D_DEFINES_SVH
`define NEAREST_POINT_SEARCH_3D_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define NPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NPS_ASSERT_IMPL(label, ante, cons, msg)
`define NPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/nps_pkg.sv
package nps_pkg;

    // Coordinate format and derived widths.
    localparam int COORD_WIDTH = 16;
    localparam int AXES        = 3;
    localparam int PT_W        = AXES * COORD_WIDTH;
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int DSQ_W       = SQ_W + 2;
    localparam int DIST_W      = DSQ_W / 2;

    // Store depth default.
    localparam int MAX_POINTS_DEFAULT = 1024;

    // Result field widths.
    localparam int QNUM_W      = 16;
    localparam int NEAREST_W   = 10;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;
    localparam int OUT_FIELDS_W = QNUM_W + NEAREST_W + DSQ_W + DIST_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Control that travels alongside each point through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } dist_ctl_t;

endpackage

FILE: hdl/nearest_point_search_3d.sv
// Clear items and appends that fit are accepted back to back.
// A query over N stored points streams one point a cycle through the store read port
// and the distance pipeline, then takes 17 steps of the root unit.
// Empty-set queries and dropped appends go straight to the emit state and skip the scan.
// Reset (aresetn, synchronous, active low) clears the point count, the query counter,
// the sequencer and the output valid; the point store itself is not cleared.
`include "nearest_point_search_3d_defines.svh"

module nearest_point_search_3d
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // s_tdata fields from bit 0: coord_x, coord_y, coord_z
    input  logic [PT_W-1:0]         s_tdata,
    // s_tuser fields from bit 0: operation
    input  logic [OP_W-1:0]         s_tuser,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // m_tdata fields from bit 0: query_number, nearest_index, distance_squared,
    // distance, then zero padding
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // m_tuser fields from bit 0: status
    output logic [STATUS_W-1:0]     m_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [QNUM_W-1:0]       qcnt_reg;
    logic [PT_W-1:0]         qry_reg;
    logic [CNT_W-1:0]        issue_reg;
    dist_ctl_t               issue_ctl_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic [DSQ_W-1:0]        best_sq_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    logic [QNUM_W-1:0]       res_qn_reg;
    logic [NEAREST_W-1:0]    res_idx_reg;
    logic [DSQ_W-1:0]        res_dsq_reg;
    logic [DIST_W-1:0]       res_dist_reg;
    logic [STATUS_W-1:0]     res_status_reg;

    logic                    m_valid_reg;
    logic [QNUM_W-1:0]       m_qn_reg;
    logic [NEAREST_W-1:0]    m_idx_reg;
    logic [DSQ_W-1:0]        m_dsq_reg;
    logic [DIST_W-1:0]       m_dist_reg;
    logic [STATUS_W-1:0]     m_status_reg;

    logic                    accept;
    logic [OP_W-1:0]         op;
    logic                    full;
    logic                    store_wr;
    logic                    issue_last;
    logic [PT_W-1:0]         ref_point;
    dist_ctl_t               dist_ctl;
    logic [DSQ_W-1:0]        dist_sq;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [DIST_W-1:0]       sqrt_root;
    logic [NEAREST_W+IDX_W-1:0] best_idx_ext;

    // Input handshake and decode.
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign op         = s_tuser;
    assign full       = (count_reg == CNT_W'(MAX_POINTS));
    assign store_wr   = accept && (op == OP_APPEND) && !full;
    assign issue_last = (issue_reg == count_reg - CNT_W'(1));
    assign sqrt_start = (state_reg == S_SQRT_GO);
    assign best_idx_ext = {{NEAREST_W{1'b0}}, best_idx_reg};

    // Reference point store.
    nps_ref_store #(
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ref_point)
    );

    // Shared squared-distance pipeline, one point a cycle.
    nps_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (issue_ctl_reg),
        .ref_point (ref_point),
        .qry_point (qry_reg),
        .out_ctl   (dist_ctl),
        .dist_sq   (dist_sq)
    );

    // Bit-serial floor square root.
    nps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (best_sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Sequencer, running minimum and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            qcnt_reg      <= '0;
            issue_reg     <= '0;
            issue_ctl_reg <= '0;
            cmp_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            issue_ctl_reg <= '{valid: (state_reg == S_SCAN), last: issue_last};

            // Keep the earliest strictly smaller distance.
            if (dist_ctl.valid) begin
                cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
                if ((cmp_idx_reg == '0) || (dist_sq < best_sq_reg)) begin
                    best_sq_reg  <= dist_sq;
                    best_idx_reg <= cmp_idx_reg;
                end
            end

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (op)
                            OP_CLEAR: begin
                                count_reg <= '0;
                                qcnt_reg  <= '0;
                            end
                            OP_APPEND: begin
                                if (full) begin
                                    res_qn_reg     <= qcnt_reg;
                                    res_idx_reg    <= '0;
                                    res_dsq_reg    <= '0;
                                    res_dist_reg   <= '0;
                                    res_status_reg <= STATUS_FULL;
                                    state_reg      <= S_EMIT;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_QUERY: begin
                                res_qn_reg <= qcnt_reg;
                                qcnt_reg   <= qcnt_reg + QNUM_W'(1);
                                qry_reg    <= s_tdata;
                                if (count_reg == '0) begin
                                    res_idx_reg    <= '0;
                                    res_dsq_reg    <= '0;
                                    res_dist_reg   <= '0;
                                    res_status_reg <= STATUS_EMPTY;
                                    state_reg      <= S_EMIT;
                                end else begin
                                    issue_reg   <= '0;
                                    cmp_idx_reg <= '0;
                                    state_reg   <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    issue_reg <= issue_reg + CNT_W'(1);
                    if (issue_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (dist_ctl.valid && dist_ctl.last) begin
                        state_reg <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        res_idx_reg    <= best_idx_ext[NEAREST_W-1:0];
                        res_dsq_reg    <= best_sq_reg;
                        res_dist_reg   <= sqrt_root;
                        res_status_reg <= STATUS_OK;
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_qn_reg     <= res_qn_reg;
                        m_idx_reg    <= res_idx_reg;
                        m_dsq_reg    <= res_dsq_reg;
                        m_dist_reg   <= res_dist_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output channel.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_dist_reg, m_dsq_reg, m_idx_reg, m_qn_reg};
    assign m_tuser  = m_status_reg;

    // Checks on the block's own logic.
    `NPS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "point count overflow")
    `NPS_ASSERT_NEXT(a_append_count, store_wr, count_reg == $past(count_reg) + CNT_W'(1), "append did not advance the count")
    `NPS_ASSERT_IMPL(a_sqrt_state, sqrt_done, state_reg == S_SQRT_WAIT, "root finished outside its wait state")
    `NPS_ASSERT_IMPL(a_error_zero, m_valid_reg && (m_status_reg != STATUS_OK), (m_idx_reg == '0) && (m_dsq_reg == '0) && (m_dist_reg == '0), "error result with nonzero fields")
    `NPS_ASSERT_IMPL(a_root_floor, m_valid_reg && (m_status_reg == STATUS_OK), (36'(m_dist_reg) * 36'(m_dist_reg) <= 36'(m_dsq_reg)) && ((36'(m_dist_reg) + 36'd1) * (36'(m_dist_reg) + 36'd1) > 36'(m_dsq_reg)), "distance is not the floor root")

endmodule

FILE: hdl/nps_ref_store.sv
module nps_ref_store
    import nps_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [PT_W-1:0]       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [PT_W-1:0]       rd_data
);

    logic [PT_W-1:0] mem [DEPTH];
    logic [PT_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/nps_dist_unit.sv
module nps_dist_unit
    import nps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dist_ctl_t         in_ctl,
    input  logic [PT_W-1:0]   ref_point,
    input  logic [PT_W-1:0]   qry_point,
    output dist_ctl_t         out_ctl,
    output logic [DSQ_W-1:0]  dist_sq
);

    logic signed [COORD_WIDTH:0] diff_reg [AXES];
    logic [SQ_W-1:0]             sq_reg [AXES];
    logic [DSQ_W-1:0]            sum_reg;
    dist_ctl_t                   ctl1_reg;
    dist_ctl_t                   ctl2_reg;
    dist_ctl_t                   ctl3_reg;

    // Stage one: per-axis difference, sign-extended by one bit.
    always_ff @(posedge aclk) begin
        for (int a = 0; a < AXES; a++) begin
            diff_reg[a] <= $signed({qry_point[a*COORD_WIDTH+COORD_WIDTH-1],
                                    qry_point[a*COORD_WIDTH +: COORD_WIDTH]})
                         - $signed({ref_point[a*COORD_WIDTH+COORD_WIDTH-1],
                                    ref_point[a*COORD_WIDTH +: COORD_WIDTH]});
        end
    end

    // Stage two: square each difference; the result is never negative.
    always_ff @(posedge aclk) begin
        logic signed [2*COORD_WIDTH+1:0] prod;
        for (int a = 0; a < AXES; a++) begin
            prod      = diff_reg[a] * diff_reg[a];
            sq_reg[a] <= prod[SQ_W-1:0];
        end
    end

    // Stage three: sum of the three squares.
    always_ff @(posedge aclk) begin
        sum_reg <= DSQ_W'(sq_reg[0]) + DSQ_W'(sq_reg[1]) + DSQ_W'(sq_reg[2]);
    end

    // Control travels with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    assign out_ctl = ctl3_reg;
    assign dist_sq = sum_reg;

endmodule

FILE: hdl/nps_sqrt.sv
module nps_sqrt
    import nps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DSQ_W-1:0]  radicand,
    output logic              done,
    output logic [DIST_W-1:0] root
);

    localparam int STEP_W = $clog2(DIST_W + 1);
    localparam int REM_W  = DIST_W + 1;

    logic [DSQ_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              take;

    // One result bit per step: bring down two radicand bits and try 4r+1.
    always_comb begin
        rem_sh   = {rem_reg, rad_reg[DSQ_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        take     = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= STEP_W'(DIST_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[DSQ_W-3:0], 2'b00};
                rem_reg  <= take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg <= {root_reg[DIST_W-2:0], take};
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
